>>> src/tq_pkg.sv
// ----------------------------------------------------------------------------
// tq_pkg: timer queue shared types and constants
// Field widths, operation and status codes, and the per-cell slot record.
// ----------------------------------------------------------------------------
package tq_pkg;

  localparam int OP_W     = 2;
  localparam int TIME_W   = 48;
  localparam int ID_W     = 32;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ARM         = 2'd0,
    OP_CHECK       = 2'd1,
    OP_CANCEL      = 2'd2,
    OP_CANCEL_UPTO = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // One timer slot; kill marks an entry waiting to be squeezed out.
  typedef struct packed {
    logic              valid;
    logic              kill;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
  } slot_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    op_t               op;
    logic              mark;
    logic              compact;
    logic [ID_W-1:0]   target_id;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   new_id;
    logic [TIME_W-1:0] new_deadline;
    logic [TAG_W-1:0]  new_tag;
  } cell_ctrl_t;

endpackage

>>> src/tq_req_if.sv
// ----------------------------------------------------------------------------
// tq_req_if: timer queue request channel
// Valid/ready handshake carrying one timer operation.
// ----------------------------------------------------------------------------
interface tq_req_if import tq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] delay;
  logic [ID_W-1:0]   target_id;
  logic [TAG_W-1:0]  tag;
  logic              release_req;

  modport source (
    output valid, op, now, delay, target_id, tag, release_req,
    input  ready
  );
  modport sink (
    input  valid, op, now, delay, target_id, tag, release_req,
    output ready
  );
endinterface

>>> src/tq_rsp_if.sv
// ----------------------------------------------------------------------------
// tq_rsp_if: timer queue response channel
// Valid/ready handshake carrying the result of one timer operation.
// ----------------------------------------------------------------------------
interface tq_rsp_if import tq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     event_id;
  logic [TAG_W-1:0]    event_tag;
  logic                release_request;
  logic [COUNT_W-1:0]  removed_count;
  logic [COUNT_W-1:0]  pending_count;
  logic [TIME_W-1:0]   head_remaining;

  modport source (
    output valid, status, event_id, event_tag, release_request,
           removed_count, pending_count, head_remaining,
    input  ready
  );
  modport sink (
    input  valid, status, event_id, event_tag, release_request,
           removed_count, pending_count, head_remaining,
    output ready
  );
endinterface

>>> src/timer_queue_with_cancel.sv
// ----------------------------------------------------------------------------
// timer_queue_with_cancel: ordered timer table with expiry check and cancel
// Holds up to DEPTH timers oldest first in a chain of slot cells.
// ----------------------------------------------------------------------------
// Sequence: arm, or any op that removes nothing, passes from acceptance
// through the execute and finish states to its result; an op that removes
// timers also passes the compact state, which closes one gap per cycle.
// Throughput: one transaction at a time; the next request is taken the cycle
// after the result register loads, even while that result is still waiting.
// Reset: all slots empty, next id 1, no clearing pass.
module timer_queue_with_cancel import tq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic     clk,
  input logic     rst,
  tq_req_if.sink  req,
  tq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_EXEC    = 4'b0010,
    S_COMPACT = 4'b0100,
    S_FINISH  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Latched request
  op_t               req_op;
  logic [TIME_W-1:0] req_now;
  logic [TIME_W-1:0] req_deadline;
  logic [ID_W-1:0]   req_target;
  logic [TAG_W-1:0]  req_tag;
  logic              req_rel;

  logic [ID_W-1:0]   next_id;
  logic [CNT_W-1:0]  pending;
  logic [CNT_W-1:0]  removed;

  // Result fields gathered while the op runs
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [TAG_W-1:0]  res_tag;
  logic              res_rel;

  logic [TIME_W:0]   sum_deadline;
  logic              full;
  logic              do_arm;
  logic              kill_any;
  logic [ID_W-1:0]   hit_id;
  logic [TAG_W-1:0]  hit_tag;
  logic              out_free;
  logic [ID_W-1:0]   id_inc;

  cell_ctrl_t        ctrl;
  slot_t             slots [DEPTH];
  logic              hits  [DEPTH];
  logic [DEPTH:0]    shift_chain;
  logic [DEPTH:0]    seen_chain;

  assign req.ready = (state == S_IDLE);
  assign full      = (pending == CNT_W'(DEPTH));
  assign do_arm    = (state == S_EXEC) && (req_op == OP_ARM) && !full;
  assign kill_any  = shift_chain[DEPTH];
  assign out_free  = !rsp.valid || rsp.ready;
  assign id_inc    = next_id + ID_W'(1);

  assign sum_deadline = {1'b0, req.now} + {1'b0, req.delay};

  always_comb begin
    ctrl.op           = req_op;
    ctrl.mark         = (state == S_EXEC) && (req_op != OP_ARM);
    ctrl.compact      = (state == S_COMPACT) && kill_any;
    ctrl.target_id    = req_target;
    ctrl.now          = req_now;
    ctrl.new_id       = next_id;
    ctrl.new_deadline = req_deadline;
    ctrl.new_tag      = req_tag;
  end

  assign shift_chain[0] = 1'b0;
  assign seen_chain[0]  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t right;
    if (i < DEPTH - 1) begin : g_mid
      assign right = slots[i+1];
    end else begin : g_last
      assign right = '0;
    end

    tq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .head      (i == 0),
      .load      (do_arm && (pending == CNT_W'(i))),
      .right     (right),
      .shift_in  (shift_chain[i]),
      .shift_out (shift_chain[i+1]),
      .seen_in   (seen_chain[i]),
      .seen_out  (seen_chain[i+1]),
      .hit       (hits[i]),
      .slot      (slots[i])
    );
  end

  // At most one cell raises hit, so an OR picks its fields
  always_comb begin
    hit_id  = '0;
    hit_tag = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_id  = hit_id  | (hits[i] ? slots[i].id  : '0);
      hit_tag = hit_tag | (hits[i] ? slots[i].tag : '0);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (req.valid) state_next = S_EXEC;
      S_EXEC: begin
        if (req_op != OP_ARM && seen_chain[DEPTH]) state_next = S_COMPACT;
        else                                       state_next = S_FINISH;
      end
      S_COMPACT: if (!kill_any) state_next = S_FINISH;
      S_FINISH:  if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_id   <= ID_W'(1);
      pending   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready)   rsp.valid <= 1'b0;
      if (do_arm) begin
        next_id <= (id_inc == '0) ? ID_W'(1) : id_inc;
        pending <= pending + CNT_W'(1);
      end
      if (ctrl.compact) pending <= pending - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      req_op       <= op_t'(req.op);
      req_now      <= req.now;
      req_deadline <= sum_deadline[TIME_W] ? '1 : sum_deadline[TIME_W-1:0];
      req_target   <= req.target_id;
      req_tag      <= req.tag;
      req_rel      <= req.release_req;
    end

    if (state == S_EXEC) begin
      removed <= '0;
      if (req_op == OP_ARM) begin
        res_status <= full ? ST_FULL : ST_DONE;
        res_id     <= full ? '0 : next_id;
        res_tag    <= '0;
        res_rel    <= 1'b0;
      end else begin
        res_status <= seen_chain[DEPTH] ? ST_DONE : ST_MISS;
        res_id     <= hit_id;
        res_tag    <= hit_tag;
        res_rel    <= (req_op == OP_CANCEL) && seen_chain[DEPTH] && req_rel;
      end
    end

    if (ctrl.compact) removed <= removed + CNT_W'(1);

    if (state == S_FINISH && out_free) begin
      rsp.status          <= res_status;
      rsp.event_id        <= res_id;
      rsp.event_tag       <= res_tag;
      rsp.release_request <= res_rel;
      rsp.removed_count   <= COUNT_W'(removed);
      rsp.pending_count   <= COUNT_W'(pending);
      if (slots[0].valid && slots[0].deadline > req_now)
        rsp.head_remaining <= slots[0].deadline - req_now;
      else
        rsp.head_remaining <= '0;
    end
  end

  // Removal flags only live between the match cycle and the end of compaction
  a_no_kill_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FINISH) |-> !kill_any)
    else $error("removal flag left set outside compaction");

  // The count and the head slot agree once the table is compacted
  a_pending_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((pending == '0) == !slots[0].valid))
    else $error("pending count disagrees with head slot");

  // Cancel by id and expiry drop at most one timer
  a_single_remove: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && req_op != OP_CANCEL_UPTO) |-> (removed <= CNT_W'(1)))
    else $error("more than one timer removed by a single-entry op");

endmodule

>>> src/tq_cell.sv
// ----------------------------------------------------------------------------
// tq_cell: one timer slot of the queue chain
// Loads an armed entry, matches the broadcast request, flags its entry for
// removal and takes its right neighbor's entry while the chain closes a gap.
// ----------------------------------------------------------------------------
module tq_cell import tq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       head,
  input  logic       load,
  input  slot_t      right,
  input  logic       shift_in,
  output logic       shift_out,
  input  logic       seen_in,
  output logic       seen_out,
  output logic       hit,
  output slot_t      slot
);

  logic cand;
  logic match;
  logic kill_set;

  always_comb begin
    unique case (ctrl.op)
      OP_CHECK:       match = head && (slot.deadline <= ctrl.now);
      OP_CANCEL:      match = (slot.id == ctrl.target_id);
      OP_CANCEL_UPTO: match = (slot.id <= ctrl.target_id);
      default:        match = 1'b0;
    endcase
  end

  assign cand     = ctrl.mark && slot.valid && match;
  assign hit      = cand && !seen_in;
  assign seen_out = seen_in || cand;
  // Cancel-up-to drops every match, the other ops only the first one
  assign kill_set = (ctrl.op == OP_CANCEL_UPTO) ? cand : hit;

  // Once a flagged entry is seen, it and everything behind it moves left
  assign shift_out = shift_in || slot.kill;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
      slot.kill  <= 1'b0;
    end else if (load) begin
      slot.valid    <= 1'b1;
      slot.kill     <= 1'b0;
      slot.id       <= ctrl.new_id;
      slot.deadline <= ctrl.new_deadline;
      slot.tag      <= ctrl.new_tag;
    end else if (ctrl.mark) begin
      slot.kill <= kill_set;
    end else if (ctrl.compact && shift_out) begin
      slot <= right;
    end
  end

endmodule

>>> tb/timer_queue_with_cancel_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_queue_with_cancel_test: self-checking bench for the timer queue
// Arms, expires and cancels timers through the request channel. A queue-based
// model of the timer table predicts every response, and the bench compares it
// field by field. Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module timer_queue_with_cancel_test;
  import tq_pkg::*;

  localparam int TQ_DEPTH       = 16;
  localparam int RAND_ITEMS     = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};

  typedef struct {
    op_t               op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delay;
    logic [ID_W-1:0]   target_id;
    logic [TAG_W-1:0]  tag;
    logic              release_req;
    bit                drain;      // hold off until all responses are back
  } timer_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     event_id;
    logic [TAG_W-1:0]    event_tag;
    logic                release_request;
    logic [COUNT_W-1:0]  removed_count;
    logic [COUNT_W-1:0]  pending_count;
    logic [TIME_W-1:0]   head_remaining;
  } timer_rsp_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
  } timer_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tq_req_if req ();
  tq_rsp_if rsp ();

  timer_queue_with_cancel dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Timer table model, oldest first
  timer_entry_t     armed_timers[$];
  logic [ID_W-1:0]  next_timer_id;

  timer_cmd_t timer_cmds[$];
  timer_rsp_t pending_results[$];
  int total_cmds;
  int drv_cnt = 0;
  int acc_cnt = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  function automatic void reset_timer_model();
    armed_timers.delete();
    next_timer_id = ID_W'(1);
  endfunction

  function automatic timer_rsp_t apply_timer_op(timer_cmd_t c);
    timer_rsp_t r;
    timer_entry_t e;
    timer_entry_t kept[$];
    logic [TIME_W:0] sum;
    int hit;
    r.status          = ST_MISS;
    r.event_id        = '0;
    r.event_tag       = '0;
    r.release_request = 1'b0;
    r.removed_count   = '0;
    r.head_remaining  = '0;
    hit = -1;
    case (c.op)
      OP_ARM: begin
        if (armed_timers.size() >= TQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          sum = {1'b0, c.now} + {1'b0, c.delay};
          e.id = next_timer_id;
          e.deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          e.tag = c.tag;
          armed_timers.push_back(e);
          r.event_id = next_timer_id;
          next_timer_id = next_timer_id + ID_W'(1);
          if (next_timer_id == 0) next_timer_id = ID_W'(1);
          r.status = ST_DONE;
        end
      end
      OP_CHECK: begin
        if (armed_timers.size() > 0 && armed_timers[0].deadline <= c.now) begin
          r.event_id = armed_timers[0].id;
          r.event_tag = armed_timers[0].tag;
          r.removed_count = COUNT_W'(1);
          r.status = ST_DONE;
          void'(armed_timers.pop_front());
        end
      end
      OP_CANCEL: begin
        foreach (armed_timers[i])
          if (hit < 0 && armed_timers[i].id == c.target_id) hit = i;
        if (hit >= 0) begin
          r.event_id = armed_timers[hit].id;
          r.event_tag = armed_timers[hit].tag;
          r.release_request = c.release_req;
          r.removed_count = COUNT_W'(1);
          r.status = ST_DONE;
          armed_timers.delete(hit);
        end
      end
      default: begin
        foreach (armed_timers[i]) begin
          if (armed_timers[i].id <= c.target_id) begin
            if (r.removed_count == 0) begin
              r.event_id = armed_timers[i].id;
              r.event_tag = armed_timers[i].tag;
            end
            r.removed_count = r.removed_count + COUNT_W'(1);
          end else begin
            kept.push_back(armed_timers[i]);
          end
        end
        if (r.removed_count != 0) r.status = ST_DONE;
        armed_timers = kept;
      end
    endcase
    r.pending_count = COUNT_W'(armed_timers.size());
    if (armed_timers.size() > 0 && armed_timers[0].deadline > c.now)
      r.head_remaining = armed_timers[0].deadline - c.now;
    return r;
  endfunction

  function automatic timer_cmd_t timer_cmd(op_t op, logic [TIME_W-1:0] now,
                                           logic [TIME_W-1:0] delay,
                                           logic [ID_W-1:0] target_id,
                                           logic [TAG_W-1:0] tag, logic rel);
    timer_cmd_t c;
    c.op = op;
    c.now = now;
    c.delay = delay;
    c.target_id = target_id;
    c.tag = tag;
    c.release_req = rel;
    c.drain = 1'b0;
    return c;
  endfunction

  // The model runs along while stimulus is built, so targets can hit live ids
  task automatic queue_cmd(timer_cmd_t c);
    void'(apply_timer_op(c));
    timer_cmds.push_back(c);
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [ID_W-1:0] live_id(int max_idx);
    int k;
    k = $urandom_range(0, max_idx);
    if (k >= armed_timers.size()) k = armed_timers.size() - 1;
    return armed_timers[k].id;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    if (fail_count < 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
    fail_count++;
  endtask

  task automatic check_result(timer_rsp_t want, timer_rsp_t got);
    if (got.status !== want.status)
      note_mismatch("status", 64'(want.status), 64'(got.status));
    if (got.event_id !== want.event_id)
      note_mismatch("event_id", 64'(want.event_id), 64'(got.event_id));
    if (got.event_tag !== want.event_tag)
      note_mismatch("event_tag", 64'(want.event_tag), 64'(got.event_tag));
    if (got.release_request !== want.release_request)
      note_mismatch("release_request", 64'(want.release_request),
                    64'(got.release_request));
    if (got.removed_count !== want.removed_count)
      note_mismatch("removed_count", 64'(want.removed_count), 64'(got.removed_count));
    if (got.pending_count !== want.pending_count)
      note_mismatch("pending_count", 64'(want.pending_count), 64'(got.pending_count));
    if (got.head_remaining !== want.head_remaining)
      note_mismatch("head_remaining", 64'(want.head_remaining),
                    64'(got.head_remaining));
  endtask

  // Driver and receiver stall control, both change on the falling edge
  always @(negedge clk) begin
    timer_cmd_t c;
    int req_idle_pct;
    int rsp_idle_pct;
    if (rst) begin
      req.valid <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      case (drv_cnt * 3 / total_cmds)
        0: begin
          req_idle_pct = 36;
          rsp_idle_pct = 73;
        end
        1: begin
          req_idle_pct = 73;
          rsp_idle_pct = 36;
        end
        default: begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      rsp.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      // hold the current transaction until it is taken
      if (!(req.valid && acc_cnt != drv_cnt)) begin
        if (timer_cmds.size() == 0 ||
            (timer_cmds[0].drain && pending_results.size() != 0) ||
            $urandom_range(0, 99) < req_idle_pct) begin
          req.valid <= 1'b0;
        end else begin
          c = timer_cmds.pop_front();
          req.valid       <= 1'b1;
          req.op          <= c.op;
          req.now         <= c.now;
          req.delay       <= c.delay;
          req.target_id   <= c.target_id;
          req.tag         <= c.tag;
          req.release_req <= c.release_req;
          drv_cnt++;
        end
      end
    end
  end

  // Monitor, predictor and watchdog on the rising edge
  always @(posedge clk) begin
    timer_cmd_t c;
    timer_rsp_t got;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (rsp.valid && rsp.ready) begin
        moved = 1'b1;
        got.status          = rsp.status;
        got.event_id        = rsp.event_id;
        got.event_tag       = rsp.event_tag;
        got.release_request = rsp.release_request;
        got.removed_count   = rsp.removed_count;
        got.pending_count   = rsp.pending_count;
        got.head_remaining  = rsp.head_remaining;
        if (pending_results.size() == 0) begin
          if (fail_count < 10) $display("%0t: response with no request outstanding", $realtime);
          fail_count++;
        end else begin
          check_result(pending_results.pop_front(), got);
        end
      end
      if (req.valid && req.ready) begin
        moved = 1'b1;
        c = timer_cmd(op_t'(req.op), req.now, req.delay, req.target_id, req.tag,
                      req.release_req);
        pending_results.push_back(apply_timer_op(c));
        acc_cnt++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] t;
    timer_cmd_t c;
    int n;
    int kind;
    int len;
    int roll;

    reset_timer_model();
    // empty table, saturation, expiry exactly at the deadline, misses
    queue_cmd(timer_cmd(OP_CHECK, '0, '0, '0, '0, 1'b0));
    queue_cmd(timer_cmd(OP_CANCEL, '0, '0, 1, '0, 1'b1));
    queue_cmd(timer_cmd(OP_CANCEL_UPTO, '0, '0, ID_MAX, '0, 1'b0));
    queue_cmd(timer_cmd(OP_ARM, '0, '0, '0, '0, 1'b0));
    queue_cmd(timer_cmd(OP_ARM, TIME_MAX, TIME_MAX, ID_MAX, 16'hffff, 1'b1));
    queue_cmd(timer_cmd(OP_ARM, TIME_W'(100), TIME_W'(50), '0, 16'h5a5a, 1'b0));
    queue_cmd(timer_cmd(OP_CHECK, '0, '0, '0, '0, 1'b0));
    queue_cmd(timer_cmd(OP_CHECK, '0, '0, '0, '0, 1'b0));
    queue_cmd(timer_cmd(OP_CANCEL, TIME_W'(100), '0, 2, '0, 1'b1));
    queue_cmd(timer_cmd(OP_CHECK, TIME_W'(149), '0, '0, '0, 1'b0));
    queue_cmd(timer_cmd(OP_CHECK, TIME_W'(150), '0, '0, '0, 1'b0));
    queue_cmd(timer_cmd(OP_CANCEL, TIME_W'(150), '0, 99, '0, 1'b1));
    queue_cmd(timer_cmd(OP_ARM, TIME_W'(200), TIME_W'(10), '0, 16'h0001, 1'b0));
    queue_cmd(timer_cmd(OP_ARM, TIME_W'(200), TIME_W'(20), '0, 16'h0002, 1'b0));
    queue_cmd(timer_cmd(OP_ARM, TIME_W'(200), TIME_W'(30), '0, 16'h0003, 1'b0));
    queue_cmd(timer_cmd(OP_CANCEL_UPTO, TIME_W'(200), '0, 5, '0, 1'b1));
    queue_cmd(timer_cmd(OP_CANCEL_UPTO, TIME_W'(200), '0, '0, '0, 1'b0));
    queue_cmd(timer_cmd(OP_CANCEL, TIME_W'(200), '0, 6, '0, 1'b0));

    t = TIME_W'(1000);
    n = 0;
    while (n < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      len = (kind < 50) ? $urandom_range(1, 8) :
            (kind < 65) ? $urandom_range(8, 20) :
            (kind < 85) ? $urandom_range(1, 6) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        t = t + TIME_W'($urandom_range(0, 40));
        if ($urandom_range(0, 99) < 2) t = TIME_MAX - TIME_W'($urandom_range(0, 500));
        c = timer_cmd(OP_ARM, t, TIME_W'($urandom_range(0, 300)), '0,
                      TAG_W'($urandom()), 1'($urandom_range(0, 1)));
        if (kind < 50) begin
          // mixed traffic against live timers
          roll = $urandom_range(0, 99);
          c.op = (roll < 40) ? OP_ARM : (roll < 70) ? OP_CHECK :
                 (roll < 85) ? OP_CANCEL : OP_CANCEL_UPTO;
          if (c.op == OP_CANCEL)
            c.target_id = (armed_timers.size() > 0 && $urandom_range(0, 99) < 85) ?
                          live_id(TQ_DEPTH - 1) : ID_W'($urandom());
          else if (c.op == OP_CANCEL_UPTO)
            c.target_id = (armed_timers.size() > 0 && $urandom_range(0, 99) < 70) ?
                          live_id(3) :
                          ($urandom_range(0, 1) ? ID_MAX : ID_W'($urandom_range(0, 3)));
        end else if (kind >= 65 && kind < 85) begin
          // expiry run: move time up to the head deadline
          c.op = OP_CHECK;
          if (armed_timers.size() > 0 && $urandom_range(0, 99) < 70) begin
            t = armed_timers[0].deadline + TIME_W'($urandom_range(0, 2));
            c.now = t;
          end
        end else if (kind >= 85) begin
          c.op = op_t'($urandom_range(0, 3));
          c.now = rand_time();
          c.delay = rand_time();
          c.target_id = ID_W'($urandom());
        end
        if (i == 0 && (n == 0 || $urandom_range(0, 99) < 3)) c.drain = 1'b1;
        queue_cmd(c);
        n++;
      end
    end
    reset_timer_model();
    total_cmds = timer_cmds.size();

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (acc_cnt != total_cmds || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d responses never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
